// ===== rtl/amed_pkg.sv =====
// ----------------------------------------------------------------------------
// amed_pkg
// Shared types and constants of the approximate match edit distance unit.
// ----------------------------------------------------------------------------
package amed_pkg;

  localparam int QIDX_W   = 7;
  localparam int SYM_IN_W = 8;
  localparam int POS_W    = 32;
  localparam int DIST_O_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // input tdata layout
  localparam int S_TDATA_W = 56;
  localparam int QIDX_LO   = 0;
  localparam int QSYM_LO   = QIDX_LO + QIDX_W;
  localparam int TSYM_LO   = QSYM_LO + SYM_IN_W;
  localparam int START_LO  = TSYM_LO + SYM_IN_W;

  // input tuser layout
  localparam int S_TUSER_W   = 2;
  localparam int TUSER_REQ   = 0;
  localparam int TUSER_FIRST = 1;

  // output tdata layout
  localparam int M_TDATA_W = POS_W + DIST_O_W;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 2'd1;

  // control part of an item moving down the row
  typedef struct packed {
    logic              valid;
    logic              is_text;
    logic              first;
    logic              last;
    logic [QIDX_W-1:0] qidx;
    logic [POS_W-1:0]  pos;
  } item_ctl_t;

endpackage

// ===== rtl/amed_cell.sv =====
// ----------------------------------------------------------------------------
// amed_cell
// One row of the edit distance column: holds a query symbol and the row value,
// updates on each text item passing through and hands the item downward.
// ----------------------------------------------------------------------------
module amed_cell
  import amed_pkg::*;
#(
  parameter int IDX         = 1,
  parameter int MAX_QUERY   = 128,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic [CFG_DATA_W-1:0]                 query_length,
  input  item_ctl_t                             in_ctl,
  input  logic [SYMBOL_BITS-1:0]                in_tsym,
  input  logic [SYMBOL_BITS-1:0]                in_qsym,
  input  logic [$clog2(MAX_QUERY+1)-1:0]        in_up_new,
  input  logic [$clog2(MAX_QUERY+1)-1:0]        in_up_old,
  output item_ctl_t                             out_ctl,
  output logic [SYMBOL_BITS-1:0]                out_tsym,
  output logic [SYMBOL_BITS-1:0]                out_qsym,
  output logic [$clog2(MAX_QUERY+1)-1:0]        out_up_new,
  output logic [$clog2(MAX_QUERY+1)-1:0]        out_up_old
);

  localparam int DIST_W = $clog2(MAX_QUERY + 1);
  localparam logic [DIST_W-1:0] RAMP = DIST_W'(IDX);

  logic [SYMBOL_BITS-1:0] qsym;
  logic [DIST_W-1:0]      value;

  logic              active;
  logic              match;
  logic              load_here;
  logic              text_here;
  logic [DIST_W-1:0] old_val;
  logic [DIST_W-1:0] min_a;
  logic [DIST_W-1:0] min_b;
  logic [DIST_W-1:0] new_val;
  logic [DIST_W-1:0] pass_new;

  always_comb begin
    active    = 32'(query_length) >= 32'(IDX);
    text_here = advance && in_ctl.valid && (in_ctl.is_text == REQ_TEXT);
    load_here = advance && in_ctl.valid && (in_ctl.is_text == REQ_LOAD) &&
                (32'(in_ctl.qidx) == 32'(IDX - 1));
    // an area start sees the ramp instead of the stored row value
    old_val   = in_ctl.first ? RAMP : value;
    match     = (qsym == in_tsym);
    min_a     = (in_up_old < old_val) ? in_up_old : old_val;
    min_b     = (in_up_new < min_a) ? in_up_new : min_a;
    if (!active) begin
      new_val = old_val;
    end else if (match) begin
      new_val = in_up_old;
    end else begin
      new_val = min_b + DIST_W'(1);
    end
    // rows past the query length hand the bottom value straight through
    pass_new  = active ? new_val : in_up_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= RAMP;
    end else if (text_here) begin
      value <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (load_here) begin
      qsym <= in_qsym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (advance) begin
      out_ctl.valid   <= in_ctl.valid;
      out_ctl.is_text <= in_ctl.is_text;
      out_ctl.first   <= in_ctl.first;
      out_ctl.last    <= in_ctl.last;
      out_ctl.qidx    <= in_ctl.qidx;
      out_ctl.pos     <= in_ctl.pos;
      out_tsym        <= in_tsym;
      out_qsym        <= in_qsym;
      out_up_new      <= pass_new;
      out_up_old      <= old_val;
    end
  end

endmodule

// ===== rtl/approximate_match_edit_distance_unit.sv =====
// ----------------------------------------------------------------------------
// approximate_match_edit_distance_unit
// Semi-global edit distance of a stored query against a text stream, built
// as a systolic row of query cells.
//
//   channel  signals                           use
//   s_*      tvalid tready tdata tuser tlast   load and text items in
//   m_*      tvalid tready tdata tuser tlast   one result per text item
//   cfg_*    valid ready index data            register writes
//
// one item enters per cycle while the row is not held; a result is registered
// by each row of the cell row in turn (the first row taking the item at its
// accepting edge) and then by the output register
// load items travel the row too, so each cell sees loads and text in order
// reset: rows go to 0..MAX_QUERY, position to zero, registers to 1 and 0
// when the output register is full and m_tready is low the whole row holds
// ----------------------------------------------------------------------------
module approximate_match_edit_distance_unit
  import amed_pkg::*;
#(
  parameter int MAX_QUERY   = 128,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // query_index, query_symbol, text_symbol, first_position, zero pad
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // req_type, first_of_area
  input  logic [S_TUSER_W-1:0]   s_tuser,
  input  logic                   s_tlast,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // end_position, distance
  output logic [M_TDATA_W-1:0]   m_tdata,
  // is_hit
  output logic [0:0]             m_tuser,
  output logic                   m_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIST_W = $clog2(MAX_QUERY + 1);

  logic [CFG_DATA_W-1:0] query_length;
  logic [CFG_DATA_W-1:0] error_threshold;
  logic [POS_W-1:0]      pos_cnt;

  logic                  advance;
  logic                  in_text;
  logic                  in_first;
  logic [POS_W-1:0]      in_pos;

  item_ctl_t              link_ctl  [0:MAX_QUERY];
  logic [SYMBOL_BITS-1:0] link_tsym [0:MAX_QUERY];
  logic [SYMBOL_BITS-1:0] link_qsym [0:MAX_QUERY];
  logic [DIST_W-1:0]      link_new  [0:MAX_QUERY];
  logic [DIST_W-1:0]      link_old  [0:MAX_QUERY];

  logic [31:0]           dist_ext;
  logic [DIST_O_W-1:0]   dist_sat;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length    <= CFG_DATA_W'(1);
      error_threshold <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUERY_LENGTH:    query_length    <= cfg_data;
        CFG_ERROR_THRESHOLD: error_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_text  = (s_tuser[TUSER_REQ] == REQ_TEXT);
    in_first = s_tuser[TUSER_FIRST];
    in_pos   = in_first ? s_tdata[START_LO +: POS_W] : pos_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (s_tvalid && s_tready && in_text) begin
      pos_cnt <= in_pos + POS_W'(1);
    end
  end

  always_comb begin
    link_ctl[0].valid   = s_tvalid;
    link_ctl[0].is_text = in_text;
    link_ctl[0].first   = in_first;
    link_ctl[0].last    = s_tlast;
    link_ctl[0].qidx    = s_tdata[QIDX_LO +: QIDX_W];
    link_ctl[0].pos     = in_pos;
    link_tsym[0]        = s_tdata[TSYM_LO +: SYMBOL_BITS];
    link_qsym[0]        = s_tdata[QSYM_LO +: SYMBOL_BITS];
    // row zero is always zero, before and after each text item
    link_new[0]         = '0;
    link_old[0]         = '0;
  end

  for (genvar g = 1; g <= MAX_QUERY; g++) begin : g_row
    amed_cell #(
      .IDX         (g),
      .MAX_QUERY   (MAX_QUERY),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .query_length (query_length),
      .in_ctl       (link_ctl[g-1]),
      .in_tsym      (link_tsym[g-1]),
      .in_qsym      (link_qsym[g-1]),
      .in_up_new    (link_new[g-1]),
      .in_up_old    (link_old[g-1]),
      .out_ctl      (link_ctl[g]),
      .out_tsym     (link_tsym[g]),
      .out_qsym     (link_qsym[g]),
      .out_up_new   (link_new[g]),
      .out_up_old   (link_old[g])
    );
  end

  always_comb begin
    dist_ext = 32'(link_new[MAX_QUERY]);
    dist_sat = (dist_ext > 32'd255) ? {DIST_O_W{1'b1}} : dist_ext[DIST_O_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= link_ctl[MAX_QUERY].valid && (link_ctl[MAX_QUERY].is_text == REQ_TEXT);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= {dist_sat, link_ctl[MAX_QUERY].pos};
      m_tuser[0] <= (dist_sat <= error_threshold);
      m_tlast    <= link_ctl[MAX_QUERY].last;
    end
  end

endmodule

// ===== test/approximate_match_edit_distance_unit_test.sv =====
// ----------------------------------------------------------------------------
// approximate_match_edit_distance_unit_test
// Streams query loads and text areas into the matcher and predicts each text
// result with a local edit-distance column. Results are compared in order by
// position, distance, hit flag and area end. Register settings change between
// drained phases. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module approximate_match_edit_distance_unit_test
  import amed_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUERY_DEPTH   = 128;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TEXT    = 85;

  typedef struct {
    logic              req_type;
    logic [QIDX_W-1:0] qidx;
    logic [7:0]        qsym;
    logic [7:0]        tsym;
    logic              first;
    logic              last;
    logic [31:0]       start;
  } symbol_req_t;

  typedef struct {
    logic [31:0] pos;
    logic [7:0]  edit_dist;
    logic        hit;
    logic        done;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [7:0]  query_bank [QUERY_DEPTH];
  int          edit_col [QUERY_DEPTH + 1];
  logic [31:0] position;
  logic [7:0]  cfg_query_length;
  logic [7:0]  cfg_threshold;

  // stimulus side view of the query store
  logic [7:0]  planned_query [QUERY_DEPTH];

  symbol_req_t pending_requests[$];
  match_t      pending_matches[$];
  symbol_req_t on_bus;
  match_t      want;
  logic        sent_last_edge = 1'b0;
  bit          steady = 1'b0;

  int mismatches = 0;
  int texts_taken = 0;
  int loads_taken = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int areas_closed = 0;
  int settings_written = 0;

  approximate_match_edit_distance_unit #(
    .MAX_QUERY   (QUERY_DEPTH),
    .SYMBOL_BITS (8)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // advance the edit column by one text item and queue the match it reports; a load only stores its symbol
  function automatic void advance_edit_column(input symbol_req_t r);
    int     i;
    int     rows;
    int     diag;
    int     up_old;
    int     best;
    match_t res;
    if (r.req_type == REQ_LOAD) begin
      query_bank[r.qidx] = r.qsym;
      loads_taken++;
      return;
    end
    texts_taken++;
    if (r.first) begin
      for (i = 0; i <= QUERY_DEPTH; i++) edit_col[i] = i;
      position = r.start;
    end
    rows = (cfg_query_length > QUERY_DEPTH) ? QUERY_DEPTH : int'(cfg_query_length);
    edit_col[0] = 0;
    diag = 0;
    for (i = 1; i <= rows; i++) begin
      up_old = edit_col[i];
      best = diag;
      if (query_bank[i-1] != r.tsym) begin
        if (up_old < best) best = up_old;
        if (edit_col[i-1] < best) best = edit_col[i-1];
        best++;
      end
      diag = up_old;
      edit_col[i] = best;
    end
    res.pos = position;
    position = position + 32'd1;
    res.edit_dist = (edit_col[rows] > 255) ? 8'hFF : 8'(edit_col[rows]);
    res.hit = (res.edit_dist <= cfg_threshold);
    res.done = r.last;
    pending_matches = {pending_matches, res};
  endfunction

  // mostly a four-letter alphabet so that matches happen
  function automatic logic [7:0] pick_symbol();
    logic [7:0] alphabet [4];
    alphabet = '{8'h41, 8'h43, 8'h47, 8'h54};
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return alphabet[$urandom_range(3)];
  endfunction

  function automatic void push_load(input int idx, input logic [7:0] sym);
    symbol_req_t r;
    r.req_type = REQ_LOAD;
    r.qidx = QIDX_W'(idx);
    r.qsym = sym;
    r.tsym = 8'($urandom_range(255));
    r.first = 1'($urandom_range(1));
    r.last = 1'($urandom_range(1));
    r.start = $urandom();
    planned_query[idx] = sym;
    pending_requests = {pending_requests, r};
  endfunction

  function automatic void push_text(input logic [7:0] sym, input logic first,
                                    input logic last, input logic [31:0] start);
    symbol_req_t r;
    r.req_type = REQ_TEXT;
    r.qidx = QIDX_W'($urandom_range(127));
    r.qsym = 8'($urandom_range(255));
    r.tsym = sym;
    r.first = first;
    r.last = last;
    r.start = first ? start : $urandom();
    pending_requests = {pending_requests, r};
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_QUERY_LENGTH) cfg_query_length = val;
    else if (idx == CFG_ERROR_THRESHOLD) cfg_threshold = val;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every item is in and every match is out, then let loads clear the row
  task automatic settle();
    while (pending_requests.size() != 0 || s_tvalid || pending_matches.size() != 0)
      @(posedge clk);
    repeat (QUERY_DEPTH + 32) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || sent_last_edge) begin
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
        on_bus = pending_requests.pop_front();
        // pad, first_position, text_symbol, query_symbol, query_index
        s_tdata <= {1'b0, on_bus.start, on_bus.tsym, on_bus.qsym, on_bus.qidx};
        s_tuser <= {on_bus.first, on_bus.req_type};
        s_tlast <= on_bus.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sent_last_edge <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) advance_edit_column(on_bus);
  end

  // receiver
  always @(negedge clk) begin
    m_tready <= steady || $urandom_range(99) >= 23;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result pos %h dist %0d", $time,
                 m_tdata[POS_W-1:0], m_tdata[POS_W +: DIST_O_W]);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (m_tdata[POS_W-1:0] !== want.pos) begin
          $display("%0t: end_position expected %h actual %h", $time, want.pos,
                   m_tdata[POS_W-1:0]);
          mismatches++;
        end
        if (m_tdata[POS_W +: DIST_O_W] !== want.edit_dist) begin
          $display("%0t: distance at %h expected %0d actual %0d", $time, want.pos,
                   want.edit_dist, m_tdata[POS_W +: DIST_O_W]);
          mismatches++;
        end
        if (m_tuser[0] !== want.hit) begin
          $display("%0t: is_hit at %h expected %b actual %b", $time, want.pos,
                   want.hit, m_tuser[0]);
          mismatches++;
        end
        if (m_tlast !== want.done) begin
          $display("%0t: area_done at %h expected %b actual %b", $time, want.pos,
                   want.done, m_tlast);
          mismatches++;
        end
        if (want.hit) hits_seen++;
        if (want.done) areas_closed++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0]  syms[$];
    logic [31:0] start;
    logic [7:0]  qlen;
    logic [7:0]  thr;
    int          rows;
    int          text_in_phase;
    int          k;
    int          phase;

    for (k = 0; k <= QUERY_DEPTH; k++) edit_col[k] = k;
    for (k = 0; k < QUERY_DEPTH; k++) begin
      query_bank[k] = '0;
      planned_query[k] = '0;
    end
    position = '0;
    cfg_query_length = 8'd1;
    cfg_threshold = 8'd0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, text before any area start counts from zero
    push_load(0, 8'hFF);
    push_text(8'hFF, 1'b0, 1'b0, 32'd0);
    push_text(8'h00, 1'b0, 1'b0, 32'd0);
    settle();

    // empty query always matches, position wraps past the top
    write_register(CFG_QUERY_LENGTH, 8'd0);
    write_register(CFG_ERROR_THRESHOLD, 8'd0);
    push_text(8'h5A, 1'b1, 1'b0, 32'hFFFF_FFFF);
    push_text(8'h00, 1'b0, 1'b1, 32'd0);
    settle();

    // three-symbol query: exact, substituted, shortened and far areas
    write_register(CFG_QUERY_LENGTH, 8'd3);
    write_register(CFG_ERROR_THRESHOLD, 8'd1);
    push_load(1, 8'h00);
    push_load(2, 8'h80);
    push_load(127, 8'h7F);
    push_text(8'hFF, 1'b1, 1'b0, 32'd0);
    push_text(8'h00, 1'b0, 1'b0, 32'd0);
    push_text(8'h80, 1'b0, 1'b1, 32'd0);
    push_text(8'hFF, 1'b1, 1'b0, 32'd50);
    push_text(8'h01, 1'b0, 1'b0, 32'd0);
    push_text(8'h80, 1'b0, 1'b1, 32'd0);
    push_text(8'hFF, 1'b1, 1'b0, 32'd60);
    push_text(8'h80, 1'b0, 1'b1, 32'd0);
    push_text(8'h11, 1'b1, 1'b0, 32'h8000_0000);
    push_text(8'h22, 1'b0, 1'b1, 32'd0);
    push_text(8'hFF, 1'b1, 1'b0, 32'd100);
    settle();

    // shorter query inside the open area, upper rows keep their values
    write_register(CFG_QUERY_LENGTH, 8'd1);
    push_text(8'h00, 1'b0, 1'b0, 32'd0);
    push_text(8'hFF, 1'b0, 1'b1, 32'd0);
    settle();

    for (k = 0; k < QUERY_DEPTH; k++) push_load(k, pick_symbol());
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        qlen = 8'hFF;
        thr = 8'hFF;
      end else if (phase == 1) begin
        qlen = 8'(QUERY_DEPTH);
        thr = 8'd0;
      end else begin
        case ($urandom_range(7))
          0: qlen = 8'd0;
          1: qlen = 8'($urandom_range(129, 255));
          2: qlen = 8'($urandom_range(17, 128));
          default: qlen = 8'($urandom_range(1, 16));
        endcase
        thr = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
      end
      write_register(CFG_QUERY_LENGTH, qlen);
      write_register(CFG_ERROR_THRESHOLD, thr);
      rows = (qlen > QUERY_DEPTH) ? QUERY_DEPTH : int'(qlen);
      steady = (phase == 4);
      text_in_phase = 0;
      while (text_in_phase < PHASE_TEXT) begin
        case ($urandom_range(9))
          0: begin
            push_text(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom());
            text_in_phase++;
          end
          1: push_load($urandom_range(127), pick_symbol());
          default: begin
            syms.delete();
            start = ($urandom_range(7) == 0) ? 32'hFFFF_FFF8 + 32'($urandom_range(7))
                                             : $urandom();
            if (rows > 0 && rows <= 40 && $urandom_range(1) == 1) begin
              // plant the query with a few edits
              repeat ($urandom_range(3)) syms = {syms, pick_symbol()};
              for (k = 0; k < rows; k++) begin
                case ($urandom_range(15))
                  0: ;
                  1: syms = {syms, pick_symbol()};
                  2: begin
                    syms = {syms, pick_symbol()};
                    syms = {syms, planned_query[k]};
                  end
                  default: syms = {syms, planned_query[k]};
                endcase
              end
              repeat ($urandom_range(3)) syms = {syms, pick_symbol()};
            end else begin
              repeat ($urandom_range(1, 24)) syms = {syms, pick_symbol()};
            end
            if (syms.size() == 0) syms = {syms, pick_symbol()};
            foreach (syms[j]) push_text(syms[j], j == 0, j == syms.size() - 1, start);
            text_in_phase += syms.size();
          end
        endcase
      end
      settle();
    end
    steady = 1'b0;

    $display("ran %0d text and %0d load items over %0d register writes, %0d areas closed",
             texts_taken, loads_taken, settings_written, areas_closed);
    $display("compared %0d results, %0d of them hits", results_checked, hits_seen);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
